// File: rtl/core/gbfis_pkg.sv
`timescale 1ns / 1ps

package gbfis_pkg;

  localparam int Rows   = 64;
  localparam int Cols   = 128;
  localparam int MaxRes = 32;

  localparam int RowAw   = $clog2(Rows);
  localparam int RowBits = 2 * Cols;
  localparam int CntW    = $clog2(MaxRes + 1);

  // fixed item field widths
  localparam int RowFw  = 6;
  localparam int ColFw  = 7;
  localparam int HighFw = 7;

  localparam logic KindWrite = 1'b0;
  localparam logic KindQuery = 1'b1;

  typedef enum logic [1:0] {
    CELL_FREE     = 2'd0,
    CELL_SOFT     = 2'd1,
    CELL_HARD     = 2'd2,
    CELL_FREE_ALT = 2'd3
  } gbfis_cell_e;

  typedef enum logic [1:0] {
    CLS_FREE,
    CLS_SOFT,
    CLS_HARD
  } gbfis_cls_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR,
    ST_SEARCH,
    ST_RUN,
    ST_SKIP,
    ST_DONE
  } gbfis_state_e;

  typedef struct packed {
    logic              kind;
    logic [RowFw-1:0]  cell_row;
    logic [ColFw-1:0]  cell_col;
    logic [1:0]        cell_code;
    logic [ColFw-1:0]  band_first;
    logic [ColFw-1:0]  band_last;
    logic [RowFw-1:0]  row_from;
  } gbfis_req_t;

  typedef struct packed {
    logic              found;
    logic [RowFw-1:0]  first_free;
    logic              has_interval;
    logic [RowFw-1:0]  run_low;
    logic [HighFw-1:0] run_high;
    logic              last;
  } gbfis_res_t;

  typedef struct packed {
    logic               rd_en;
    logic [RowAw-1:0]   rd_addr;
    logic               wr_en;
    logic [RowAw-1:0]   wr_addr;
    logic [RowBits-1:0] wr_data;
  } gbfis_mem_req_t;

endpackage

// File: rtl/core/gbfis_grid_store.sv
`timescale 1ns / 1ps

module gbfis_grid_store (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  gbfis_pkg::gbfis_mem_req_t        mem_i,
  output logic [gbfis_pkg::RowBits-1:0]    rd_data_o
);
  import gbfis_pkg::*;

  logic [RowBits-1:0] mem_q [Rows];
  logic [RowBits-1:0] rd_data_q;
  logic [Rows-1:0]    row_valid_q;
  logic               rd_valid_q;

  // one row word per entry; never-written rows read as all free
  always_ff @(posedge clk_i) begin
    if (mem_i.wr_en) begin
      mem_q[mem_i.wr_addr] <= mem_i.wr_data;
    end
    if (mem_i.rd_en) begin
      rd_data_q <= mem_q[mem_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (mem_i.wr_en) begin
        row_valid_q[mem_i.wr_addr] <= 1'b1;
      end
      if (mem_i.rd_en) begin
        rd_valid_q <= row_valid_q[mem_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

// File: rtl/core/gbfis_scan_ctrl.sv
`timescale 1ns / 1ps

module gbfis_scan_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  gbfis_pkg::gbfis_req_t         req_i,
  output logic                          res_strobe_o,
  output gbfis_pkg::gbfis_res_t         res_o,
  output gbfis_pkg::gbfis_mem_req_t     mem_o,
  input  logic [gbfis_pkg::RowBits-1:0] rd_data_i
);
  import gbfis_pkg::*;

  gbfis_state_e       state_q, state_d;
  logic               strobe_q, strobe_d;
  gbfis_res_t         res_q, res_d;
  logic               found_q, found_d;
  logic               pend_q, pend_d;
  logic [CntW-1:0]    n_q, n_d;
  logic [Cols-1:0]    mask_q, mask_d;
  logic [RowAw-1:0]   row_q, row_d;
  logic [RowAw-1:0]   start_q, start_d;
  logic [RowAw-1:0]   ff_q, ff_d;
  logic [RowAw-1:0]   lo_q, lo_d;
  logic [RowAw-1:0]   hi_q, hi_d;
  logic [RowAw-1:0]   wr_row_q, wr_row_d;
  logic [ColFw-1:0]   wr_col_q, wr_col_d;
  logic [1:0]         wr_code_q, wr_code_d;
  logic               wr_ok_q, wr_ok_d;

  logic [Cols-1:0]    hard_v, soft_v;
  gbfis_cls_e         cls;
  logic [RowBits-1:0] new_word;
  logic               rec;
  logic               scanning;
  logic               accept;

  // row classification over the band, within the row word
  always_comb begin
    for (int c = 0; c < Cols; c++) begin
      hard_v[c] = mask_q[c] && (rd_data_i[2*c +: 2] == CELL_HARD);
      soft_v[c] = mask_q[c] && (rd_data_i[2*c +: 2] == CELL_SOFT);
    end
    if (|hard_v) begin
      cls = CLS_HARD;
    end else if (|soft_v) begin
      cls = CLS_SOFT;
    end else begin
      cls = CLS_FREE;
    end
  end

  always_comb begin
    for (int c = 0; c < Cols; c++) begin
      new_word[2*c +: 2] = (c == int'(wr_col_q)) ? wr_code_q : rd_data_i[2*c +: 2];
    end
  end

  assign accept   = start && !busy;
  assign scanning = (state_q == ST_SEARCH) || (state_q == ST_RUN) || (state_q == ST_SKIP);

  always_comb begin
    state_d   = state_q;
    strobe_d  = 1'b0;
    res_d     = '0;
    found_d   = found_q;
    pend_d    = pend_q;
    n_d       = n_q;
    mask_d    = mask_q;
    row_d     = row_q;
    start_d   = start_q;
    ff_d      = ff_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    wr_row_d  = wr_row_q;
    wr_col_d  = wr_col_q;
    wr_code_d = wr_code_q;
    wr_ok_d   = wr_ok_q;
    mem_o     = '0;
    rec       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.kind == KindWrite) begin
            wr_row_d      = req_i.cell_row[RowAw-1:0];
            wr_col_d      = req_i.cell_col;
            wr_code_d     = req_i.cell_code;
            wr_ok_d       = (int'(req_i.cell_row) < Rows) && (int'(req_i.cell_col) < Cols);
            mem_o.rd_en   = 1'b1;
            mem_o.rd_addr = req_i.cell_row[RowAw-1:0];
            state_d       = ST_WR;
          end else begin
            for (int c = 0; c < Cols; c++) begin
              mask_d[c] = (c >= int'(req_i.band_first)) && (c <= int'(req_i.band_last));
            end
            found_d = 1'b0;
            pend_d  = 1'b0;
            n_d     = '0;
            row_d   = req_i.row_from[RowAw-1:0];
            if (int'(req_i.row_from) < Rows) begin
              mem_o.rd_en   = 1'b1;
              mem_o.rd_addr = req_i.row_from[RowAw-1:0];
              state_d       = ST_SEARCH;
            end else begin
              state_d = ST_DONE;
            end
          end
        end
      end
      ST_WR: begin
        mem_o.wr_en   = wr_ok_q;
        mem_o.wr_addr = wr_row_q;
        mem_o.wr_data = new_word;
        state_d       = ST_IDLE;
      end
      ST_SEARCH: begin
        if (cls == CLS_FREE) begin
          found_d = 1'b1;
          ff_d    = row_q;
          start_d = row_q;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        unique case (cls)
          CLS_SOFT: begin
            rec     = 1'b1;
            state_d = ST_SKIP;
          end
          CLS_HARD: begin
            rec     = 1'b1;
            state_d = ST_DONE;
          end
          default: ;
        endcase
      end
      ST_SKIP: begin
        unique case (cls)
          CLS_HARD: state_d = ST_DONE;
          CLS_FREE: begin
            start_d = row_q;
            state_d = ST_RUN;
          end
          default: ;
        endcase
      end
      ST_DONE: begin
        strobe_d = 1'b1;
        res_d.last = 1'b1;
        if (found_q) begin
          res_d.found      = 1'b1;
          res_d.first_free = RowFw'(ff_q);
          if (pend_q) begin
            res_d.has_interval = 1'b1;
            res_d.run_low      = RowFw'(lo_q);
            res_d.run_high     = HighFw'(hi_q);
          end
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    if (scanning) begin
      row_d = row_q + RowAw'(1);
      if (row_q != RowAw'(Rows - 1)) begin
        mem_o.rd_en   = 1'b1;
        mem_o.rd_addr = row_q + RowAw'(1);
      end else if (state_d != ST_DONE) begin
        // free run still open at the top row: dropped
        state_d = ST_DONE;
      end
    end

    // a closed run is held back until the next one closes or the scan ends, so that the final one carries last
    if (rec && (n_q < CntW'(MaxRes))) begin
      if (pend_q) begin
        strobe_d           = 1'b1;
        res_d.found        = 1'b1;
        res_d.first_free   = RowFw'(ff_q);
        res_d.has_interval = 1'b1;
        res_d.run_low      = RowFw'(lo_q);
        res_d.run_high     = HighFw'(hi_q);
        res_d.last         = 1'b0;
      end
      pend_d = 1'b1;
      lo_d   = start_q;
      hi_d   = row_q;
      n_d    = n_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_q <= 1'b0;
      found_q  <= 1'b0;
      pend_q   <= 1'b0;
      n_q      <= '0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
      found_q  <= found_d;
      pend_q   <= pend_d;
      n_q      <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q     <= res_d;
    mask_q    <= mask_d;
    row_q     <= row_d;
    start_q   <= start_d;
    ff_q      <= ff_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    wr_row_q  <= wr_row_d;
    wr_col_q  <= wr_col_d;
    wr_code_q <= wr_code_d;
    wr_ok_q   <= wr_ok_d;
  end

  assign busy         = (state_q != ST_IDLE);
  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule

// File: rtl/core/grid_band_free_interval_scan.sv
`timescale 1ns / 1ps

// Banded free-interval scan over a 64 x 128 grid of 2-bit cells, one row word per
// entry of a synchronous memory with one read and one write port. An item is taken when
// start is high and busy is low. A cell write reads the row, then writes it back. A query
// reads one row per cycle from row_from upwards until a hard row after the first free
// row, or the top row, ends the scan. Results are registered and appear in the cycle
// after they are decided, each for exactly one cycle on res_strobe_o; the receiver
// cannot hold them off and must take every one. A query gives one or more results,
// the final one flagged by last. The grid reads as all free after reset, with no
// clearing pass.
module grid_band_free_interval_scan (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  gbfis_pkg::gbfis_req_t req_i,
  output logic                  res_strobe_o,
  output gbfis_pkg::gbfis_res_t res_o
);
  import gbfis_pkg::*;

  gbfis_mem_req_t     mem_req;
  logic [RowBits-1:0] rd_data;

  gbfis_grid_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mem_i     (mem_req),
    .rd_data_o (rd_data)
  );

  gbfis_scan_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o),
    .mem_o        (mem_req),
    .rd_data_i    (rd_data)
  );

endmodule

// File: rtl/core/gbfis_checker.sv
`timescale 1ns / 1ps

module gbfis_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start,
  input logic                  busy,
  input gbfis_pkg::gbfis_req_t req_i,
  input logic                  res_strobe_o,
  input gbfis_pkg::gbfis_res_t res_o
);
  import gbfis_pkg::*;

  // a taken item makes the block busy in the cycle after it is taken
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block idle right after taking an item");

  a_notfound_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !res_o.found) |->
      (res_o.last && !res_o.has_interval && (res_o.first_free == '0)))
    else $error("failed query result malformed");

  a_empty_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !res_o.has_interval) |-> res_o.last)
    else $error("result without a run is not final");

  a_run_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.has_interval) |->
      (res_o.found && (HighFw'(res_o.run_low) < res_o.run_high)
       && (res_o.run_low >= res_o.first_free)))
    else $error("run bounds inconsistent");

endmodule

bind grid_band_free_interval_scan gbfis_checker u_checker (.*);

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import gbfis_pkg::*;

  localparam int IdleLimit    = 2000;
  localparam int SettleCycles = 100;
  localparam int TargetItems  = 330;

  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start  = 1'b0;
  logic       busy;
  gbfis_req_t req_i  = '0;
  logic       res_strobe_o;
  gbfis_res_t res_o;

  grid_band_free_interval_scan u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

  always #1 clk_i = ~clk_i;

  logic [1:0] grid_model [Rows][Cols];
  gbfis_req_t cmd_q[$];
  bit         drain_q[$];   // hold this item back until every pending interval is out
  gbfis_res_t interval_q[$];
  int         errors      = 0;
  int         idle_cycles = 0;
  int         burst_left  = 0;
  int         gap_left    = 0;

  function automatic gbfis_res_t make_interval(bit found, int ff, bit has, int lo, int hi,
                                               bit fin);
    gbfis_res_t r;
    r.found        = found;
    r.first_free   = RowFw'(ff);
    r.has_interval = has;
    r.run_low      = RowFw'(lo);
    r.run_high     = HighFw'(hi);
    r.last         = fin;
    return r;
  endfunction

  // Classify every row over the band, then walk up from the first free row.
  function automatic void predict_intervals(gbfis_req_t q);
    gbfis_cls_e cls [Rows];
    gbfis_res_t res_buf [MaxRes];
    int n, s, g, run_start, hi_col;
    n = 0;
    hi_col = (int'(q.band_last) < Cols) ? int'(q.band_last) : Cols - 1;
    for (int r = 0; r < Rows; r++) begin
      cls[r] = CLS_FREE;
      for (int c = int'(q.band_first); c <= hi_col; c++) begin
        if (grid_model[r][c] == CELL_HARD) begin
          cls[r] = CLS_HARD;
        end else if (grid_model[r][c] == CELL_SOFT && cls[r] == CLS_FREE) begin
          cls[r] = CLS_SOFT;
        end
      end
    end
    s = int'(q.row_from);
    while (s < Rows && cls[s] != CLS_FREE) s++;
    if (s >= Rows) begin
      interval_q = {interval_q, make_interval(1'b0, 0, 1'b0, 0, 0, 1'b1)};
      return;
    end
    run_start = s;
    g = s;
    while (g < Rows) begin
      if (cls[g] == CLS_HARD) begin
        if (g > run_start && n < MaxRes) begin
          res_buf[n] = make_interval(1'b1, s, 1'b1, run_start, g, 1'b0);
          n++;
        end
        break;
      end else if (cls[g] == CLS_SOFT) begin
        if (g > run_start && n < MaxRes) begin
          res_buf[n] = make_interval(1'b1, s, 1'b1, run_start, g, 1'b0);
          n++;
        end
        while (g < Rows && cls[g] == CLS_SOFT) g++;
        if (g < Rows && cls[g] == CLS_HARD) break;
        if (g < Rows) run_start = g;
      end
      g++;
    end
    // a run still open at the top row is dropped
    if (n == 0) begin
      interval_q = {interval_q, make_interval(1'b1, s, 1'b0, 0, 0, 1'b1)};
    end else begin
      res_buf[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) interval_q = {interval_q, res_buf[i]};
    end
  endfunction

  function automatic void push_write(int row, int col, int code);
    gbfis_req_t r;
    r.kind       = KindWrite;
    r.cell_row   = RowFw'(row);
    r.cell_col   = ColFw'(col);
    r.cell_code  = 2'(code);
    r.band_first = ColFw'($urandom);
    r.band_last  = ColFw'($urandom);
    r.row_from   = RowFw'($urandom);
    cmd_q   = {cmd_q, r};
    drain_q = {drain_q, 1'b0};
  endfunction

  function automatic void push_query(int first, int last, int from, bit drain);
    gbfis_req_t r;
    r.kind       = KindQuery;
    r.cell_row   = RowFw'($urandom);
    r.cell_col   = ColFw'($urandom);
    r.cell_code  = 2'($urandom);
    r.band_first = ColFw'(first);
    r.band_last  = ColFw'(last);
    r.row_from   = RowFw'(from);
    cmd_q   = {cmd_q, r};
    drain_q = {drain_q, drain};
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : drive
    gbfis_req_t cur;
    logic       nxt_start;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      nxt_start = start;
      if (start && !busy) begin
        cur = cmd_q.pop_front();
        void'(drain_q.pop_front());
        if (cur.kind == KindWrite) begin
          grid_model[cur.cell_row][cur.cell_col] = cur.cell_code;
        end else begin
          predict_intervals(cur);
        end
        nxt_start = 1'b0;
      end
      if (!nxt_start && cmd_q.size() != 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!(drain_q[0] && interval_q.size() != 0)) begin
          nxt_start = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      start <= nxt_start;
      if (nxt_start) req_i <= cmd_q[0];
    end
  end

  always @(posedge clk_i) begin : observe
    gbfis_res_t want;
    if (rst_ni && res_strobe_o) begin
      if (interval_q.size() == 0) begin
        $display("%0t: unexpected item: expected none, actual %h", $time, res_o);
        errors++;
      end else begin
        want = interval_q.pop_front();
        check_field("found", 8'(want.found), 8'(res_o.found));
        check_field("first_free", 8'(want.first_free), 8'(res_o.first_free));
        check_field("has_interval", 8'(want.has_interval), 8'(res_o.has_interval));
        check_field("run_low", 8'(want.run_low), 8'(res_o.run_low));
        check_field("run_high", 8'(want.run_high), 8'(res_o.run_high));
        check_field("last", 8'(want.last), 8'(res_o.last));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (start && !busy) || res_strobe_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int col, base, width, f, l, from, pick, code;
    for (int r = 0; r < Rows; r++) begin
      for (int c = 0; c < Cols; c++) grid_model[r][c] = CELL_FREE;
    end

    // directed: empty grid, unclosed top run, soft/hard closures, empty band, no free row
    push_query(0, Cols - 1, 0, 1'b0);
    push_query(0, Cols - 1, Rows - 1, 1'b0);
    push_write(10, 5, CELL_HARD);
    push_write(5, 6, CELL_SOFT);
    push_write(20, 127, CELL_FREE_ALT);
    push_write(63, 0, CELL_SOFT);
    push_write(0, 127, CELL_HARD);
    push_write(40, 1, CELL_SOFT);
    push_write(41, 1, CELL_HARD);
    push_query(0, Cols - 1, 0, 1'b0);
    push_query(6, 4, 0, 1'b0);
    push_query(7, Cols - 1, 0, 1'b0);
    push_query(0, 0, 62, 1'b0);
    push_query(0, Cols - 1, Rows - 1, 1'b0);
    push_query(5, 5, 10, 1'b0);
    push_query(0, 3, 32, 1'b0);
    push_write(10, 5, CELL_FREE_ALT);
    push_write(0, 127, CELL_FREE);
    push_write(63, 127, CELL_HARD);
    push_query(0, Cols - 1, 0, 1'b0);
    push_query(127, 127, 0, 1'b0);
    push_query(0, Cols - 1, 0, 1'b1);

    // soft on every odd row of one column: the longest train of intervals
    col = $urandom_range(0, Cols - 1);
    for (int r = 1; r < Rows; r += 2) push_write(r, col, CELL_SOFT);
    push_query(col, col, 0, 1'b1);

    // scenes: writes clustered in a narrow column window, then queries around it
    while (cmd_q.size() < TargetItems) begin
      base  = $urandom_range(0, Cols - 8);
      width = $urandom_range(1, 8);
      repeat ($urandom_range(2, 14)) begin
        pick = $urandom_range(0, 19);
        code = (pick < 6) ? CELL_FREE : (pick < 8) ? CELL_FREE_ALT :
               (pick < 17) ? CELL_SOFT : CELL_HARD;
        push_write($urandom_range(0, Rows - 1), base + $urandom_range(0, width - 1), code);
      end
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 3))
          0: begin
            f = base;
            l = base + width - 1;
          end
          1: begin
            f = base + $urandom_range(0, width - 1);
            l = f + $urandom_range(0, 3);
            if (l > Cols - 1) l = Cols - 1;
          end
          2: begin
            f = $urandom_range(0, Cols - 1);
            l = $urandom_range(0, Cols - 1);
          end
          default: begin
            f = 0;
            l = Cols - 1;
          end
        endcase
        from = ($urandom_range(0, 3) == 0) ? $urandom_range(0, Rows - 1) : $urandom_range(0, 8);
        push_query(f, l, from, $urandom_range(0, 19) == 0);
      end
      if ($urandom_range(0, 3) == 0) begin
        push_write($urandom_range(0, Rows - 1), $urandom_range(0, Cols - 1), $urandom_range(0, 3));
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || interval_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/gbfis_pkg.sv
rtl/core/gbfis_grid_store.sv
rtl/core/gbfis_scan_ctrl.sv
rtl/core/grid_band_free_interval_scan.sv
rtl/core/gbfis_checker.sv
sim/testbench.sv
